// ----- rtl/ipd_pkg.sv -----
// Package for the +IPD frame parser: character codes and result type.
package ipd_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] packet_length;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
    } result_t;

endpackage

// ----- rtl/ipd_frame_parser.sv -----
// +IPD frame parser: header match, decimal length decode and payload streaming.
//
// Usage:
//   Slave stream s_axis_* carries one received serial byte per transfer.
//   Master stream m_axis_* carries one payload byte per transfer, with its
//   index and the decoded frame length; tlast marks the final payload byte.
//   Header, length digits and the ':' produce no output transfer.
//   One input byte per cycle is sustained while the skid stage is not full.
//   m_axis_tvalid is registered: parser state and the result register (or
//   the skid stage, while a result is stalled) are updated at the accepting edge.
//   The output register is backed by a one-entry skid stage, so one more
//   payload byte is taken while a result is stalled; s_axis_tready falls only when
//   the skid stage is full and recovers the cycle after the receiver takes.
//   Reset returns the parser to idle (waiting for '+') and empties both
//   result stages. A length of zero, or no digits, ends the frame at ':'.
module ipd_frame_parser #(
    parameter int MAX_DIGITS = 9,
    parameter int LEN_BITS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                        // [23:16] packet_length
    output logic        m_axis_tlast    // last_byte
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_I     = 3'd1;
    localparam logic [2:0] PH_P     = 3'd2;
    localparam logic [2:0] PH_D     = 3'd3;
    localparam logic [2:0] PH_COMMA = 3'd4;
    localparam logic [2:0] PH_LEN   = 3'd5;
    localparam logic [2:0] PH_DATA  = 3'd6;

    localparam logic [3:0] DIGITS_MAX = 4'(MAX_DIGITS);

    logic [2:0]          phase_reg, phase_next;
    logic [3:0]          digits_reg, digits_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [LEN_BITS-1:0] count_reg, count_next;

    ipd_pkg::result_t    out_reg, skid_reg, res;
    logic                out_valid_reg, skid_valid_reg;

    logic                accept, push, pop;
    logic [7:0]          b;
    logic [LEN_BITS:0]   count_inc;
    logic                last;
    logic [3:0]          digit_val;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign pop           = out_valid_reg && m_axis_tready;

    assign count_inc = {1'b0, count_reg} + {{LEN_BITS{1'b0}}, 1'b1};
    assign last      = count_inc >= {1'b0, len_reg};
    assign digit_val = 4'(b - ipd_pkg::CH_ZERO);

    always_comb
    begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        push        = 1'b0;
        res.payload_byte  = b;
        res.byte_index    = count_reg[7:0];
        res.packet_length = len_reg[7:0];
        res.last_byte     = last;
        case (phase_reg)
            PH_I, PH_P, PH_D, PH_COMMA:
            begin
                if ((phase_reg == PH_I     && b == ipd_pkg::CH_I) ||
                    (phase_reg == PH_P     && b == ipd_pkg::CH_P) ||
                    (phase_reg == PH_D     && b == ipd_pkg::CH_D) ||
                    (phase_reg == PH_COMMA && b == ipd_pkg::CH_COMMA))
                    phase_next = phase_reg + 3'd1;
                else if (b == ipd_pkg::CH_PLUS)
                    phase_next = PH_I;
                else
                    phase_next = PH_IDLE;
            end
            PH_LEN:
            begin
                if (b inside {[ipd_pkg::CH_ZERO:ipd_pkg::CH_NINE]})
                begin
                    if (digits_reg < DIGITS_MAX)
                    begin
                        len_next = (len_reg << 3) + (len_reg << 1)
                                   + {{(LEN_BITS-4){1'b0}}, digit_val};
                        digits_next = digits_reg + 4'd1;
                    end
                end
                else if (b == ipd_pkg::CH_COLON)
                begin
                    count_next = '0;
                    phase_next = (len_reg != '0) ? PH_DATA : PH_IDLE;
                end
            end
            PH_DATA:
            begin
                push       = 1'b1;
                count_next = count_inc[LEN_BITS-1:0];
                if (last)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (b == ipd_pkg::CH_PLUS)
                begin
                    phase_next  = PH_I;
                    digits_next = '0;
                    len_next    = '0;
                    count_next  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            digits_reg <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
        end
    end

    // result register with one-entry skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= accept && push;
        end
        else if (!out_valid_reg)
            out_valid_reg <= accept && push;
        else if (accept && push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else
                out_reg <= res;
        end
        else if (!out_valid_reg)
            out_reg <= res;
        else if (accept && push)
            skid_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.packet_length, out_reg.byte_index, out_reg.payload_byte};
    assign m_axis_tlast  = out_reg.last_byte;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (len_reg != '0))
        else $error("payload phase with zero length");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_digits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg <= DIGITS_MAX)
        else $error("digit count beyond limit");
`endif

endmodule

// ----- sim/ipd_frame_parser_tb.sv -----
// Self-checking testbench for the +IPD frame parser: header, length and payload streaming.
`timescale 1ns / 100ps

module ipd_frame_parser_tb;

    localparam int DIGIT_LIMIT = 9;
    localparam int ITEM_TARGET = 600;
    localparam int QUIET_FROM  = 520;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WANT_I,
        PH_WANT_P,
        PH_WANT_D,
        PH_WANT_COMMA,
        PH_LENGTH,
        PH_PAYLOAD
    } parse_phase_e;

    class payload_scoreboard;
        parse_phase_e      phase;
        int unsigned       digits;
        logic [7:0]        len_acc;
        logic [7:0]        rx_count;
        ipd_pkg::result_t  expected_payload[$];
        int unsigned       mismatches;

        function new();
            phase      = PH_IDLE;
            digits     = 0;
            len_acc    = '0;
            rx_count   = '0;
            mismatches = 0;
        endfunction

        function parse_phase_e header_step(logic [7:0] b, logic [7:0] want,
                                           parse_phase_e next_phase);
            if (b == want)
                return next_phase;
            if (b == ipd_pkg::CH_PLUS)
                return PH_WANT_I;
            return PH_IDLE;
        endfunction

        // returns 1 if the byte was not simply ignored by an idle parser
        function bit note_rx_byte(logic [7:0] b);
            ipd_pkg::result_t r;
            bit               significant;
            significant = (phase != PH_IDLE) || (b == ipd_pkg::CH_PLUS);
            case (phase)
                PH_WANT_I:     phase = header_step(b, ipd_pkg::CH_I, PH_WANT_P);
                PH_WANT_P:     phase = header_step(b, ipd_pkg::CH_P, PH_WANT_D);
                PH_WANT_D:     phase = header_step(b, ipd_pkg::CH_D, PH_WANT_COMMA);
                PH_WANT_COMMA: phase = header_step(b, ipd_pkg::CH_COMMA, PH_LENGTH);
                PH_LENGTH:
                begin
                    if (b >= ipd_pkg::CH_ZERO && b <= ipd_pkg::CH_NINE) begin
                        if (digits < DIGIT_LIMIT) begin
                            len_acc = 8'(len_acc * 10 + (b - ipd_pkg::CH_ZERO));
                            digits++;
                        end
                    end else if (b == ipd_pkg::CH_COLON) begin
                        rx_count = '0;
                        phase    = (len_acc != 0) ? PH_PAYLOAD : PH_IDLE;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.payload_byte  = b;
                    r.byte_index    = rx_count;
                    r.packet_length = len_acc;
                    r.last_byte     = (int'(rx_count) + 1 >= int'(len_acc));
                    expected_payload.push_back(r);
                    rx_count = rx_count + 8'd1;
                    if (r.last_byte)
                        phase = PH_IDLE;
                end
                default:
                begin
                    phase = PH_IDLE;
                    if (b == ipd_pkg::CH_PLUS) begin
                        phase    = PH_WANT_I;
                        digits   = 0;
                        len_acc  = '0;
                        rx_count = '0;
                    end
                end
            endcase
            return significant;
        endfunction

        function void check_payload(ipd_pkg::result_t got);
            ipd_pkg::result_t want;
            if (expected_payload.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: byte %02h idx %0d len %0d last %0b",
                             got.payload_byte, got.byte_index, got.packet_length,
                             got.last_byte);
                return;
            end
            want = expected_payload.pop_front();
            if (got.payload_byte !== want.payload_byte || got.byte_index !== want.byte_index
                || got.packet_length !== want.packet_length
                || got.last_byte !== want.last_byte) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp byte %02h idx %0d len %0d last %0b,",
                              " got byte %02h idx %0d len %0d last %0b"},
                             want.payload_byte, want.byte_index, want.packet_length,
                             want.last_byte, got.payload_byte, got.byte_index,
                             got.packet_length, got.last_byte);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    payload_scoreboard sb;
    int unsigned       items_sent;
    bit                quiet;

    ipd_frame_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(logic [7:0] b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (sb.note_rx_byte(b))
            items_sent++;
        quiet = (items_sent >= QUIET_FROM);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_frame();
        logic [7:0]  hdr[$];
        logic [7:0]  field[$];
        string       digits;
        int unsigned kind;
        int unsigned value;
        int unsigned cut;
        logic [7:0]  b;
        hdr = '{ipd_pkg::CH_PLUS, ipd_pkg::CH_I, ipd_pkg::CH_P, ipd_pkg::CH_D,
                ipd_pkg::CH_COMMA};
        if ($urandom_range(0, 4) == 0)
            send_byte(8'($urandom_range(0, 255)));
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // broken header: a wrong byte, possibly a '+', after a good prefix
            cut = $urandom_range(1, 4);
            for (int i = 0; i < cut; i++)
                send_byte(hdr[i]);
            b = 8'($urandom_range(0, 255));
            if (b == hdr[cut] || $urandom_range(0, 2) == 0)
                b = (b == hdr[cut]) ? ~b : ipd_pkg::CH_PLUS;
            send_byte(b);
            return;
        end
        foreach (hdr[i])
            send_byte(hdr[i]);
        if (kind < 72)
            value = $urandom_range(1, 12);
        else if (kind < 80)
            value = 0;
        else if (kind < 88)
            value = 256 * $urandom_range(1, 3) + $urandom_range(1, 6);
        else if (kind < 97)
            value = $urandom_range(13, 40);
        else
            value = $urandom_range(200, 255);
        digits = (value == 0 && $urandom_range(0, 1) == 0) ? "" : $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++)
            field.push_back(digits[i]);
        if ($urandom_range(0, 6) == 0) begin
            // pad to the digit limit, then trailing digits that must be ignored
            while (field.size() < DIGIT_LIMIT)
                field.push_front(ipd_pkg::CH_ZERO);
            repeat ($urandom_range(1, 3))
                field.push_back(8'(ipd_pkg::CH_ZERO + $urandom_range(0, 9)));
        end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4))
                field.push_front(ipd_pkg::CH_ZERO);
        end
        if ($urandom_range(0, 5) == 0) begin
            do
                b = 8'($urandom_range(0, 255));
            while ((b >= ipd_pkg::CH_ZERO && b <= ipd_pkg::CH_NINE) || b == ipd_pkg::CH_COLON);
            field.insert($urandom_range(0, field.size()), b);
        end
        foreach (field[i])
            send_byte(field[i]);
        send_byte(ipd_pkg::CH_COLON);
        while (sb.phase == PH_PAYLOAD)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial
    begin
        int unsigned      gap_left;
        bit               long_done;
        ipd_pkg::result_t got;
        gap_left  = 0;
        long_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.payload_byte  = m_axis_tdata[7:0];
                got.byte_index    = m_axis_tdata[15:8];
                got.packet_length = m_axis_tdata[23:16];
                got.last_byte     = m_axis_tlast;
                sb.check_payload(got);
            end
            if (gap_left != 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_done && items_sent >= HOLD_AT) begin
                long_done = 1'b1;
                gap_left  = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        sb            = new();
        items_sent    = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plus inside header with a stray byte and no digits
        send_text("+I+IPD,z:");
        // header mismatch
        send_text("+IPX");
        // leading zero, two-byte payload at the byte extremes
        send_text("+IPD,02:");
        send_byte(8'h00);
        send_byte(8'hFF);

        while (items_sent < ITEM_TARGET)
            send_frame();
        s_axis_tvalid <= 1'b0;

        while (sb.expected_payload.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_payload.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
